@@ design/esc_pkg.sv @@
// shared types, character codes and error codes of the expression syntax checker
package esc_pkg;

	localparam int DEPTH_W = 7;
	localparam int POS_W   = 8;
	localparam int CODE_W  = 4;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH = 7'd64;
	localparam logic [POS_W-1:0]   POS_MAX   = 8'hFF;

	localparam logic [1:0] PH_OPERAND = 2'd0;
	localparam logic [1:0] PH_NUMBER  = 2'd1;
	localparam logic [1:0] PH_CLOSED  = 2'd2;
	localparam logic [1:0] PH_ERROR   = 2'd3;

	localparam logic [2:0] CL_ZERO  = 3'd0;
	localparam logic [2:0] CL_DIGIT = 3'd1;
	localparam logic [2:0] CL_OP    = 3'd2;
	localparam logic [2:0] CL_OPEN  = 3'd3;
	localparam logic [2:0] CL_CLOSE = 3'd4;
	localparam logic [2:0] CL_OTHER = 3'd5;

	localparam logic [CODE_W-1:0] ERR_NONE       = 4'd0;
	localparam logic [CODE_W-1:0] ERR_BAD_CHAR   = 4'd1;
	localparam logic [CODE_W-1:0] ERR_LEAD_ZERO  = 4'd2;
	localparam logic [CODE_W-1:0] ERR_START_OP   = 4'd3;
	localparam logic [CODE_W-1:0] ERR_OP_AFTER_OPEN  = 4'd4;
	localparam logic [CODE_W-1:0] ERR_MISSING_OPEN   = 4'd5;
	localparam logic [CODE_W-1:0] ERR_OP_BEFORE_OPEN = 4'd6;
	localparam logic [CODE_W-1:0] ERR_OP_AFTER_CLOSE = 4'd7;
	localparam logic [CODE_W-1:0] ERR_DEPTH      = 4'd8;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [1:0]         phase;
		logic [DEPTH_W-1:0] depth;
		logic [POS_W-1:0]   pos;
		logic [CODE_W-1:0]  err_code;
		logic [POS_W-1:0]   err_pos;
	} state_t;

	typedef struct packed {
		logic               error_flag;
		logic [CODE_W-1:0]  error_code;
		logic [POS_W-1:0]   error_position;
		logic               end_marker;
		logic               verdict_ok;
		logic [DEPTH_W-1:0] open_depth;
	} result_t;

	function automatic logic [2:0] classify(input logic [7:0] c);
		logic [2:0] cl;
		if (c == CH_ZERO)
			cl = CL_ZERO;
		else if (c >= CH_ONE && c <= CH_NINE)
			cl = CL_DIGIT;
		else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH)
			cl = CL_OP;
		else if (c == CH_OPEN)
			cl = CL_OPEN;
		else if (c == CH_CLOSE)
			cl = CL_CLOSE;
		else
			cl = CL_OTHER;
		return cl;
	endfunction

endpackage

@@ design/esc_step.sv @@
// transition logic: one character or end beat against the current automaton state
module esc_step (
	input  esc_pkg::state_t  cur,
	input  logic             kind,
	input  logic [7:0]       char_code,
	output esc_pkg::state_t  nxt,
	output esc_pkg::result_t res
);

	logic [2:0]      cl;
	logic            open;
	logic            take;
	esc_pkg::state_t upd;
	logic            fail;
	logic [esc_pkg::CODE_W-1:0] fcode;

	assign cl   = esc_pkg::classify(char_code);
	assign open = cur.depth != '0;
	assign take = !kind && cur.phase != esc_pkg::PH_ERROR && char_code != esc_pkg::CH_SPACE;

	always_comb begin
		upd   = cur;
		fail  = 1'b0;
		fcode = esc_pkg::ERR_NONE;
		if (cl == esc_pkg::CL_OTHER) begin
			fail  = 1'b1;
			fcode = esc_pkg::ERR_BAD_CHAR;
		end else if (cur.phase == esc_pkg::PH_OPERAND) begin
			case (cl)
				esc_pkg::CL_ZERO: begin
					fail  = 1'b1;
					fcode = esc_pkg::ERR_LEAD_ZERO;
				end
				esc_pkg::CL_DIGIT: upd.phase = esc_pkg::PH_NUMBER;
				esc_pkg::CL_OP: begin
					fail  = 1'b1;
					fcode = open ? esc_pkg::ERR_OP_AFTER_OPEN : esc_pkg::ERR_START_OP;
				end
				esc_pkg::CL_OPEN: begin
					if (cur.depth >= esc_pkg::MAX_DEPTH) begin
						fail  = 1'b1;
						fcode = esc_pkg::ERR_DEPTH;
					end else begin
						upd.depth = cur.depth + 1'b1;
					end
				end
				default: begin
					fail  = 1'b1;
					fcode = esc_pkg::ERR_MISSING_OPEN;
				end
			endcase
		end else begin
			case (cl)
				esc_pkg::CL_ZERO, esc_pkg::CL_DIGIT: begin
					if (cur.phase == esc_pkg::PH_CLOSED) begin
						fail  = 1'b1;
						fcode = esc_pkg::ERR_OP_AFTER_CLOSE;
					end
				end
				esc_pkg::CL_OP: upd.phase = esc_pkg::PH_OPERAND;
				esc_pkg::CL_OPEN: begin
					fail  = 1'b1;
					fcode = esc_pkg::ERR_OP_BEFORE_OPEN;
				end
				default: begin
					if (open) begin
						upd.depth = cur.depth - 1'b1;
						upd.phase = esc_pkg::PH_CLOSED;
					end else begin
						fail  = 1'b1;
						fcode = esc_pkg::ERR_MISSING_OPEN;
					end
				end
			endcase
		end
		if (fail) begin
			upd.phase    = esc_pkg::PH_ERROR;
			upd.err_code = fcode;
			upd.err_pos  = cur.pos;
		end
		if (cur.pos != esc_pkg::POS_MAX)
			upd.pos = cur.pos + 1'b1;
		if (!take)
			upd = cur;
	end

	always_comb begin
		res.error_flag     = upd.phase == esc_pkg::PH_ERROR;
		res.error_code     = upd.err_code;
		res.error_position = upd.err_pos;
		res.end_marker     = kind;
		res.verdict_ok     = kind && upd.phase != esc_pkg::PH_ERROR;
		res.open_depth     = upd.depth;
	end

	always_comb begin
		nxt = upd;
		if (kind) begin
			nxt.phase    = esc_pkg::PH_OPERAND;
			nxt.depth    = '0;
			nxt.pos      = '0;
			nxt.err_code = esc_pkg::ERR_NONE;
			nxt.err_pos  = '0;
		end
	end

endmodule

@@ design/expression_syntax_checker.sv @@
// top level of the expression syntax checker: state and result registers
//
// Checks infix integer expressions fed one character per input beat.
// Input channel: in_valid/in_ready with kind (0 character, 1 end of
// expression) and char_code. Output channel: out_valid/out_ready with one
// status beat per input beat: error flag, first error code and position,
// end marker, verdict and the current count of open parentheses.
// The result is registered and appears in the cycle after its input beat
// is taken. Throughput: one beat per cycle unless the receiver stalls; the
// automaton state is updated in the same cycle the character is taken, and
// the result register sits between the two channels.
// Spaces do not advance the position; after the first error, characters
// change nothing. An end beat reports and then clears the state.
// Reset clears the automaton to "expecting operand" with depth and
// position zero and empties the result register.
// While the receiver stalls, the result holds and in_ready stays low
// until the waiting result is taken.
module expression_syntax_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [7:0]                   char_code,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         error_flag,
	output logic [esc_pkg::CODE_W-1:0]   error_code,
	output logic [esc_pkg::POS_W-1:0]    error_position,
	output logic                         end_marker,
	output logic                         verdict_ok,
	output logic [esc_pkg::DEPTH_W-1:0]  open_depth
);

	esc_pkg::state_t  state_q;
	esc_pkg::state_t  state_nxt;
	esc_pkg::result_t res;
	esc_pkg::result_t res_q;
	logic             out_valid_q;
	logic             in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	esc_step u_step (
		.cur       (state_q),
		.kind      (kind),
		.char_code (char_code),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= esc_pkg::PH_OPERAND;
			state_q.depth    <= '0;
			state_q.pos      <= '0;
			state_q.err_code <= esc_pkg::ERR_NONE;
			state_q.err_pos  <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (in_fire)
				state_q <= state_nxt;
			if (in_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign error_flag     = res_q.error_flag;
	assign error_code     = res_q.error_code;
	assign error_position = res_q.error_position;
	assign end_marker     = res_q.end_marker;
	assign verdict_ok     = res_q.verdict_ok;
	assign open_depth     = res_q.open_depth;

endmodule

@@ design/esc_checker.sv @@
// port-level assertions for the expression syntax checker and their bind
module esc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         error_flag,
	input logic [esc_pkg::CODE_W-1:0]   error_code,
	input logic [esc_pkg::POS_W-1:0]    error_position,
	input logic                         end_marker,
	input logic                         verdict_ok,
	input logic [esc_pkg::DEPTH_W-1:0]  open_depth
);

	// no waiting beat means room for input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty result register");

	a_clean_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error_flag |->
			error_code == esc_pkg::ERR_NONE && error_position == '0)
		else $error("error fields set without error flag");

	a_error_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_flag |-> error_code != esc_pkg::ERR_NONE)
		else $error("error flag with no error code");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict_ok |-> end_marker && !error_flag
			&& open_depth <= esc_pkg::MAX_DEPTH)
		else $error("verdict ok on a non-end or failed beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_code)
			&& $stable(open_depth) && $stable(end_marker))
		else $error("stalled result beat changed");

endmodule

bind expression_syntax_checker esc_checker u_esc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.error_flag     (error_flag),
	.error_code     (error_code),
	.error_position (error_position),
	.end_marker     (end_marker),
	.verdict_ok     (verdict_ok),
	.open_depth     (open_depth)
);
